// ===== src/pcrm_pkg.sv =====
// pcrm_pkg: shared types, counter map and codes for the performance counter monitor
// used by every module under src; no dependencies of its own
`default_nettype none

package pcrm_pkg;

  // default counter width, handed to the top level parameter
  localparam int unsigned COUNTER_WIDTH_DEF = 64;

  // counter map
  localparam int unsigned NUM_COUNTERS = 28;
  localparam int unsigned CTR_IDX_W    = 5;
  localparam int unsigned IDX_CYCLES   = 0;
  localparam int unsigned IDX_RETIRE   = 1;
  localparam int unsigned IDX_INTR     = 2;
  localparam int unsigned IDX_DEVICE   = 3;
  localparam int unsigned IDX_FLAG0    = 4;
  localparam int unsigned NUM_FLAGCNT  = 13;
  localparam int unsigned IDX_EXCL0    = 17;
  localparam int unsigned NUM_EXCL     = 6;
  localparam int unsigned IDX_EPIS0    = 23;
  localparam int unsigned NUM_EPIS     = 5;
  localparam logic [CTR_IDX_W-1:0] IDX_SUM = 5'd28;

  // event flag positions
  localparam int unsigned FLG_ICACHE_WAIT = 5;
  localparam int unsigned FLG_DCACHE_WAIT = 6;
  localparam int unsigned FLG_LOAD_USE    = 7;
  localparam int unsigned FLG_DIV_WAIT    = 8;
  localparam int unsigned FLG_BR_FLUSH    = 10;
  localparam int unsigned FLG_COND_RECOV  = 13;
  localparam int unsigned FLG_JALR_RECOV  = 14;
  localparam int unsigned FLG_OTHER_RECOV = 15;

  // exclusive cause codes, offset from IDX_EXCL0
  typedef enum logic [2:0] {
    CAUSE_DCACHE   = 3'd0,
    CAUSE_DIV      = 3'd1,
    CAUSE_BR_FLUSH = 3'd2,
    CAUSE_LOAD_USE = 3'd3,
    CAUSE_ICACHE   = 3'd4,
    CAUSE_OTHER    = 3'd5
  } cause_t;

  // item kinds
  typedef enum logic [1:0] {
    KIND_TICK    = 2'd0,
    KIND_RETIRE  = 2'd1,
    KIND_READ    = 2'd2,
    KIND_RESTART = 2'd3
  } kind_t;

  // configuration register indexes
  typedef enum logic [1:0] {
    CFG_MONITOR_EN = 2'd0,
    CFG_ROI_EN     = 2'd1,
    CFG_ROI_START  = 2'd2,
    CFG_ROI_END    = 2'd3
  } cfg_idx_t;

  // one input word
  typedef struct packed {
    kind_t                kind;
    logic [15:0]          event_flags;
    logic [63:0]          retire_pc;
    logic                 retire_interrupt;
    logic                 retire_device;
    logic [CTR_IDX_W-1:0] counter_index;
  } item_t;

  // one result word
  typedef struct packed {
    logic [63:0] counter_value;
    logic        region_valid;
    logic        counting_now;
    logic        sum_matches;
    logic        bad_index;
  } rd_res_t;

endpackage

`default_nettype wire

// ===== src/pcrm_in_stage.sv =====
// pcrm_in_stage: input register with valid/stall handshake
// depends on pcrm_pkg for the item word type
`default_nettype none

module pcrm_in_stage (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           in_valid,
  output logic                in_stall,
  input  wire pcrm_pkg::item_t in_item,
  input  wire logic           adv,
  output logic                item_valid,
  output pcrm_pkg::item_t     item
);
  import pcrm_pkg::*;

  logic  valid_r, valid_nxt;
  item_t item_r;

  // hold while the registered word cannot move on
  assign in_stall   = valid_r & ~adv;
  assign valid_nxt  = in_stall ? valid_r : in_valid;
  assign item_valid = valid_r;
  assign item       = item_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (!in_stall) begin
      item_r <= in_item;
    end
  end

endmodule

`default_nettype wire

// ===== src/pcrm_exec.sv =====
// pcrm_exec: configuration, region tracking, counter bank and read select
// depends on pcrm_pkg for the counter map, codes and word types
`default_nettype none

module pcrm_exec #(
  parameter int unsigned COUNTER_WIDTH = pcrm_pkg::COUNTER_WIDTH_DEF
) (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            cfg_we,
  input  wire logic [1:0]      cfg_index,
  input  wire logic [63:0]     cfg_wdata,
  input  wire logic            fire,
  input  wire pcrm_pkg::item_t item,
  output pcrm_pkg::rd_res_t    rd_res
);
  import pcrm_pkg::*;

  localparam int unsigned CW = COUNTER_WIDTH;

  // configuration
  logic        mon_en_r, roi_en_r;
  logic [63:0] start_pc_r, end_pc_r;

  // state
  logic [CW-1:0]       cnt_r [NUM_COUNTERS];
  logic [CW-1:0]       cnt_nxt [NUM_COUNTERS];
  logic [CW-1:0]       excl_sum_r, excl_sum_nxt;
  logic                open_r, open_nxt;
  logic                started_r, started_nxt;
  logic                closed_r, closed_nxt;
  logic [NUM_EPIS-1:0] last_ep_r, last_ep_nxt;

  logic                    setup_ok, counting;
  logic                    is_tick, is_retire, is_restart;
  logic                    hit_start, hit_end, start_hit, end_hit;
  logic                    tick_cnt, retire_cnt, clr_all;
  logic [NUM_EPIS-1:0]     ep, rise;
  cause_t                  cause;
  logic [NUM_COUNTERS-1:0] bump;
  logic [CW-1:0]           sel_val;
  logic                    bad;

  // configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mon_en_r   <= 1'b0;
      roi_en_r   <= 1'b0;
      start_pc_r <= '0;
      end_pc_r   <= '0;
    end else if (cfg_we) begin
      case (cfg_idx_t'(cfg_index))
        CFG_MONITOR_EN: mon_en_r   <= cfg_wdata[0];
        CFG_ROI_EN:     roi_en_r   <= cfg_wdata[0];
        CFG_ROI_START:  start_pc_r <= cfg_wdata;
        CFG_ROI_END:    end_pc_r   <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // counting condition
  assign setup_ok = mon_en_r & ~(roi_en_r & (start_pc_r == end_pc_r));
  assign counting = setup_ok & (~roi_en_r | open_r);

  assign is_tick    = fire & (item.kind == KIND_TICK);
  assign is_retire  = fire & (item.kind == KIND_RETIRE);
  assign is_restart = fire & (item.kind == KIND_RESTART);

  // region markers
  assign hit_start = (item.retire_pc == start_pc_r);
  assign hit_end   = (item.retire_pc == end_pc_r);
  assign start_hit = is_retire & setup_ok & roi_en_r & ~started_r & hit_start;
  assign end_hit   = is_retire & setup_ok & roi_en_r & ~start_hit & open_r & hit_end;

  // marker instructions are never counted
  assign retire_cnt = is_retire & setup_ok &
                      (~roi_en_r | (open_r & ~hit_start & ~hit_end));
  assign tick_cnt   = is_tick & counting;
  assign clr_all    = is_restart | start_hit;

  // episode edges
  assign ep   = {item.event_flags[FLG_OTHER_RECOV], item.event_flags[FLG_JALR_RECOV],
                 item.event_flags[FLG_COND_RECOV], item.event_flags[FLG_BR_FLUSH],
                 item.event_flags[FLG_LOAD_USE]};
  assign rise = ep & ~last_ep_r;

  // exclusive cause by priority
  always_comb begin
    if (item.event_flags[FLG_DCACHE_WAIT])      cause = CAUSE_DCACHE;
    else if (item.event_flags[FLG_DIV_WAIT])    cause = CAUSE_DIV;
    else if (item.event_flags[FLG_BR_FLUSH])    cause = CAUSE_BR_FLUSH;
    else if (item.event_flags[FLG_LOAD_USE])    cause = CAUSE_LOAD_USE;
    else if (item.event_flags[FLG_ICACHE_WAIT]) cause = CAUSE_ICACHE;
    else                                        cause = CAUSE_OTHER;
  end

  // which counters step this word
  always_comb begin
    bump = '0;
    bump[IDX_CYCLES] = tick_cnt;
    bump[IDX_RETIRE] = retire_cnt;
    bump[IDX_INTR]   = retire_cnt & item.retire_interrupt;
    bump[IDX_DEVICE] = retire_cnt & item.retire_device;
    for (int i = 0; i < NUM_FLAGCNT; i++) begin
      bump[IDX_FLAG0 + i] = tick_cnt & item.event_flags[i];
    end
    for (int i = 0; i < NUM_EXCL; i++) begin
      bump[IDX_EXCL0 + i] = tick_cnt & (cause == cause_t'(i));
    end
    for (int i = 0; i < NUM_EPIS; i++) begin
      bump[IDX_EPIS0 + i] = tick_cnt & rise[i];
    end
  end

  // next state
  always_comb begin
    for (int i = 0; i < NUM_COUNTERS; i++) begin
      if (clr_all)      cnt_nxt[i] = '0;
      else if (bump[i]) cnt_nxt[i] = cnt_r[i] + CW'(1);
      else              cnt_nxt[i] = cnt_r[i];
    end
    // the sum steps with whichever exclusive counter steps
    if (clr_all)       excl_sum_nxt = '0;
    else if (tick_cnt) excl_sum_nxt = excl_sum_r + CW'(1);
    else               excl_sum_nxt = excl_sum_r;

    if (clr_all)       last_ep_nxt = '0;
    else if (tick_cnt) last_ep_nxt = ep;
    else               last_ep_nxt = last_ep_r;

    open_nxt    = open_r;
    started_nxt = started_r;
    closed_nxt  = closed_r;
    if (is_restart) begin
      open_nxt    = 1'b0;
      started_nxt = 1'b0;
      closed_nxt  = 1'b0;
    end else if (start_hit) begin
      open_nxt    = 1'b1;
      started_nxt = 1'b1;
    end else if (end_hit) begin
      open_nxt   = 1'b0;
      closed_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_COUNTERS; i++) begin
        cnt_r[i] <= '0;
      end
      excl_sum_r <= '0;
      last_ep_r  <= '0;
      open_r     <= 1'b0;
      started_r  <= 1'b0;
      closed_r   <= 1'b0;
    end else begin
      for (int i = 0; i < NUM_COUNTERS; i++) begin
        cnt_r[i] <= cnt_nxt[i];
      end
      excl_sum_r <= excl_sum_nxt;
      last_ep_r  <= last_ep_nxt;
      open_r     <= open_nxt;
      started_r  <= started_nxt;
      closed_r   <= closed_nxt;
    end
  end

  // read select
  always_comb begin
    bad = 1'b0;
    if (item.counter_index < CTR_IDX_W'(NUM_COUNTERS)) begin
      sel_val = cnt_r[item.counter_index];
    end else if (item.counter_index == IDX_SUM) begin
      sel_val = excl_sum_r;
    end else begin
      sel_val = '0;
      bad     = 1'b1;
    end
  end

  assign rd_res.counter_value = 64'(sel_val);
  assign rd_res.region_valid  = roi_en_r & started_r & closed_r;
  assign rd_res.counting_now  = counting;
  assign rd_res.sum_matches   = (excl_sum_r == cnt_r[IDX_CYCLES]);
  assign rd_res.bad_index     = bad;

endmodule

`default_nettype wire

// ===== src/pcrm_out_stage.sv =====
// pcrm_out_stage: result register with valid/stall handshake
// depends on pcrm_pkg for the result word type
`default_nettype none

module pcrm_out_stage (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              load,
  input  wire pcrm_pkg::rd_res_t res_in,
  output logic                   out_free,
  output logic                   out_valid,
  input  wire logic              out_stall,
  output pcrm_pkg::rd_res_t      res_out
);
  import pcrm_pkg::*;

  logic    valid_r, valid_nxt;
  rd_res_t res_r;

  // register can take a word when empty or being drained
  assign out_free  = ~valid_r | ~out_stall;
  assign valid_nxt = load | (valid_r & out_stall);
  assign out_valid = valid_r;
  assign res_out   = res_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (load) begin
      res_r <= res_in;
    end
  end

endmodule

`default_nettype wire

// ===== src/perf_counter_roi_monitor.sv =====
// Performance counter monitor with stall attribution and PC-marker region gating.
// A read word passes the input register, then the result register, which offers its
// result. Throughput: one word per cycle unless a read waits on a full result register,
// set by the single update pass over the counter bank per input register word.
// Reset (synchronous, rst_n low): counters, region state, episode memory and config
// clear to zero; no clearing pass, the block takes words right after reset.
// Depends on pcrm_pkg, pcrm_in_stage, pcrm_exec and pcrm_out_stage.
`default_nettype none

module perf_counter_roi_monitor #(
  parameter int unsigned COUNTER_WIDTH = pcrm_pkg::COUNTER_WIDTH_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  // configuration
  input  wire logic        cfg_we,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [63:0] cfg_wdata,
  // input channel
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [1:0]  in_kind,
  input  wire logic [15:0] in_event_flags,
  input  wire logic [63:0] in_retire_pc,
  input  wire logic        in_retire_interrupt,
  input  wire logic        in_retire_device,
  input  wire logic [4:0]  in_counter_index,
  // result channel
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [63:0]      out_counter_value,
  output logic             out_region_valid,
  output logic             out_counting_now,
  output logic             out_sum_matches,
  output logic             out_bad_index
);
  import pcrm_pkg::*;

  item_t   in_item, item;
  logic    item_valid, is_read, adv, fire, out_free;
  rd_res_t rd_res, res_out;

  // pack input word
  assign in_item.kind             = kind_t'(in_kind);
  assign in_item.event_flags      = in_event_flags;
  assign in_item.retire_pc        = in_retire_pc;
  assign in_item.retire_interrupt = in_retire_interrupt;
  assign in_item.retire_device    = in_retire_device;
  assign in_item.counter_index    = in_counter_index;

  // a read moves on only when the result register has room
  assign is_read = (item.kind == KIND_READ);
  assign adv     = ~is_read | out_free;
  assign fire    = item_valid & adv;

  pcrm_in_stage u_in (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_item    (in_item),
    .adv        (adv),
    .item_valid (item_valid),
    .item       (item)
  );

  pcrm_exec #(
    .COUNTER_WIDTH (COUNTER_WIDTH)
  ) u_exec (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .fire      (fire),
    .item      (item),
    .rd_res    (rd_res)
  );

  pcrm_out_stage u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (fire & is_read),
    .res_in    (rd_res),
    .out_free  (out_free),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .res_out   (res_out)
  );

  // unpack result word
  assign out_counter_value = res_out.counter_value;
  assign out_region_valid  = res_out.region_valid;
  assign out_counting_now  = res_out.counting_now;
  assign out_sum_matches   = res_out.sum_matches;
  assign out_bad_index     = res_out.bad_index;

`ifndef SYNTHESIS
  // exclusive causes always account for every counted cycle
  a_sum_matches: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_sum_matches)
    else $error("exclusive sum differs from cycle count");

  // an out-of-range read returns zero
  a_bad_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_bad_index) |-> (out_counter_value == 64'd0))
    else $error("bad index read returned nonzero value");

  // input side stalls only with a word held
  a_stall_held: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> item_valid)
    else $error("input stalled with empty register");

  // a read blocked by a full result register stays put
  a_read_held: assert property (@(posedge clk) disable iff (!rst_n)
    (item_valid && is_read && out_valid && out_stall) |=> (item_valid && is_read))
    else $error("blocked read word lost");
`endif

endmodule

`default_nettype wire

// ===== dv/tb_perf_counter_roi_monitor.sv =====
// tb_perf_counter_roi_monitor: self-checking bench for the performance counter monitor
// drives ticks, writebacks, reads and restarts; a shadow of the counter bank checks reads
// depends on pcrm_pkg and perf_counter_roi_monitor
`timescale 1ns / 100ps

module tb_perf_counter_roi_monitor;
  import pcrm_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 200000;
  localparam logic [63:0] CTR_MASK = {64{1'b1}} >> (64 - COUNTER_WIDTH_DEF);
  localparam int unsigned MAX_PRINTED = 40;

  // shadow of the counter bank, region state and registers; holds the reads still due
  class perf_count_shadow;
    bit [63:0] ctr [NUM_COUNTERS];
    bit        region_open;
    bit        region_started;
    bit        region_closed;
    bit [4:0]  ep_last;
    bit        mon_en;
    bit        roi_en;
    bit [63:0] start_pc;
    bit [63:0] end_pc;
    rd_res_t   reads_due[$];
    int unsigned reads_seen;
    int unsigned errors;

    function void set_reg(cfg_idx_t idx, logic [63:0] d);
      case (idx)
        CFG_MONITOR_EN: mon_en = d[0];
        CFG_ROI_EN:     roi_en = d[0];
        CFG_ROI_START:  start_pc = d;
        CFG_ROI_END:    end_pc = d;
        default: ;
      endcase
    endfunction

    function void bump(int unsigned i);
      ctr[i] = (ctr[i] + 64'd1) & CTR_MASK;
    endfunction

    function void clear_counts();
      foreach (ctr[i]) ctr[i] = '0;
      ep_last = '0;
    endfunction

    function bit setup_ok();
      return mon_en && !(roi_en && start_pc == end_pc);
    endfunction

    function bit counting();
      return setup_ok() && (!roi_en || region_open);
    endfunction

    function bit [63:0] excl_sum();
      bit [63:0] s;
      int i;
      s = '0;
      for (i = 0; i < NUM_EXCL; i++) s += ctr[IDX_EXCL0 + i];
      return s & CTR_MASK;
    endfunction

    // one clock of events: plain counts, episode edges, exclusive cause
    function void count_tick(logic [15:0] f);
      bit [4:0] ep;
      bit [4:0] rise;
      cause_t   cause;
      int       i;
      if (!counting()) return;
      bump(IDX_CYCLES);
      for (i = 0; i < NUM_FLAGCNT; i++) if (f[i]) bump(IDX_FLAG0 + i);
      ep = {f[FLG_OTHER_RECOV], f[FLG_JALR_RECOV], f[FLG_COND_RECOV], f[FLG_BR_FLUSH],
            f[FLG_LOAD_USE]};
      rise = ep & ~ep_last;
      for (i = 0; i < NUM_EPIS; i++) if (rise[i]) bump(IDX_EPIS0 + i);
      ep_last = ep;
      if (f[FLG_DCACHE_WAIT]) cause = CAUSE_DCACHE;
      else if (f[FLG_DIV_WAIT]) cause = CAUSE_DIV;
      else if (f[FLG_BR_FLUSH]) cause = CAUSE_BR_FLUSH;
      else if (f[FLG_LOAD_USE]) cause = CAUSE_LOAD_USE;
      else if (f[FLG_ICACHE_WAIT]) cause = CAUSE_ICACHE;
      else cause = CAUSE_OTHER;
      bump(IDX_EXCL0 + cause);
    endfunction

    // writeback: region markers first, then retirement counts
    function void count_retire(logic [63:0] pc, logic intr, logic dev);
      if (setup_ok() && roi_en) begin
        if (!region_started && pc == start_pc) begin
          clear_counts();
          region_started = 1'b1;
          region_open = 1'b1;
        end else if (region_open && pc == end_pc) begin
          region_open = 1'b0;
          region_closed = 1'b1;
        end
      end
      if (!counting()) return;
      // marker instructions are never counted
      if (roi_en && (pc == start_pc || pc == end_pc)) return;
      bump(IDX_RETIRE);
      if (intr) bump(IDX_INTR);
      if (dev) bump(IDX_DEVICE);
    endfunction

    function rd_res_t read_result(logic [4:0] idx);
      rd_res_t r;
      r = '0;
      if (idx < NUM_COUNTERS) r.counter_value = ctr[idx];
      else if (idx == IDX_SUM) r.counter_value = excl_sum();
      else r.bad_index = 1'b1;
      r.counter_value = r.counter_value & CTR_MASK;
      r.region_valid = roi_en && region_started && region_closed;
      r.counting_now = counting();
      r.sum_matches = (excl_sum() == (ctr[IDX_CYCLES] & CTR_MASK));
      return r;
    endfunction

    // accepted input word
    function void apply_word(item_t w);
      case (w.kind)
        KIND_TICK:   count_tick(w.event_flags);
        KIND_RETIRE: count_retire(w.retire_pc, w.retire_interrupt, w.retire_device);
        KIND_READ:   reads_due.insert(reads_due.size(), read_result(w.counter_index));
        KIND_RESTART: begin
          clear_counts();
          region_open = 1'b0;
          region_started = 1'b0;
          region_closed = 1'b0;
        end
        default: ;
      endcase
    endfunction

    task report(string msg);
      errors++;
      if (errors <= MAX_PRINTED) $display("mismatch: %s", msg);
    endtask

    // accepted result word against the oldest read still due
    task check_read(rd_res_t got);
      rd_res_t want;
      if (reads_due.size() == 0) begin
        report($sformatf("result word with no read pending, value %0h", got.counter_value));
        return;
      end
      want = reads_due.pop_front();
      reads_seen++;
      if (got.counter_value !== want.counter_value)
        report($sformatf("read %0d counter_value %0h, want %0h", reads_seen,
                         got.counter_value, want.counter_value));
      if (got.region_valid !== want.region_valid)
        report($sformatf("read %0d region_valid %b, want %b", reads_seen,
                         got.region_valid, want.region_valid));
      if (got.counting_now !== want.counting_now)
        report($sformatf("read %0d counting_now %b, want %b", reads_seen,
                         got.counting_now, want.counting_now));
      if (got.sum_matches !== want.sum_matches)
        report($sformatf("read %0d sum_matches %b, want %b", reads_seen,
                         got.sum_matches, want.sum_matches));
      if (got.bad_index !== want.bad_index)
        report($sformatf("read %0d bad_index %b, want %b", reads_seen,
                         got.bad_index, want.bad_index));
    endtask
  endclass

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_we = 1'b0;
  logic [1:0]  cfg_index = '0;
  logic [63:0] cfg_wdata = '0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [1:0]  in_kind = '0;
  logic [15:0] in_event_flags = '0;
  logic [63:0] in_retire_pc = '0;
  logic        in_retire_interrupt = 1'b0;
  logic        in_retire_device = 1'b0;
  logic [4:0]  in_counter_index = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [63:0] out_counter_value;
  logic        out_region_valid;
  logic        out_counting_now;
  logic        out_sum_matches;
  logic        out_bad_index;

  perf_count_shadow sb = new();
  int unsigned tb_cycles = 0;
  logic [8:0]  stall_phase = '0;
  logic [15:0] prev_flags = '0;
  item_t       seen_word;
  rd_res_t     seen_result;

  perf_counter_roi_monitor dut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cfg_we              (cfg_we),
    .cfg_index           (cfg_index),
    .cfg_wdata           (cfg_wdata),
    .in_valid            (in_valid),
    .in_stall            (in_stall),
    .in_kind             (in_kind),
    .in_event_flags      (in_event_flags),
    .in_retire_pc        (in_retire_pc),
    .in_retire_interrupt (in_retire_interrupt),
    .in_retire_device    (in_retire_device),
    .in_counter_index    (in_counter_index),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_counter_value   (out_counter_value),
    .out_region_valid    (out_region_valid),
    .out_counting_now    (out_counting_now),
    .out_sum_matches     (out_sum_matches),
    .out_bad_index       (out_bad_index)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  // run limit
  always @(posedge clk) begin
    tb_cycles <= tb_cycles + 1;
    if (tb_cycles >= CYCLE_LIMIT) begin
      $display("tb_perf_counter_roi_monitor: FAIL");
      $finish;
    end
  end

  // receiver stall: mode set by the top two bits of a free-running phase counter
  always @(negedge clk) begin
    stall_phase <= stall_phase + 9'd1;
    case (stall_phase[8:7])
      2'd0: out_stall <= 1'b0;
      2'd1: out_stall <= ($urandom_range(0, 3) == 0);
      2'd2: out_stall <= ($urandom_range(0, 3) != 0);
      default: out_stall <= (stall_phase[2:0] < 3'd5);
    endcase
  end

  // both handshakes sampled at the rising edge
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && !in_stall) begin
        seen_word.kind = kind_t'(in_kind);
        seen_word.event_flags = in_event_flags;
        seen_word.retire_pc = in_retire_pc;
        seen_word.retire_interrupt = in_retire_interrupt;
        seen_word.retire_device = in_retire_device;
        seen_word.counter_index = in_counter_index;
        sb.apply_word(seen_word);
      end
      if (out_valid === 1'b1 && out_stall === 1'b0) begin
        seen_result.counter_value = out_counter_value;
        seen_result.region_valid = out_region_valid;
        seen_result.counting_now = out_counting_now;
        seen_result.sum_matches = out_sum_matches;
        seen_result.bad_index = out_bad_index;
        sb.check_read(seen_result);
      end
    end
  end

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  function automatic item_t mk(kind_t k, logic [15:0] f, logic [63:0] pc, logic intr,
                               logic dev, logic [4:0] idx);
    item_t w;
    w.kind = k;
    w.event_flags = f;
    w.retire_pc = pc;
    w.retire_interrupt = intr;
    w.retire_device = dev;
    w.counter_index = idx;
    return w;
  endfunction

  // random word; flags often follow the previous tick so episodes carry over between ticks
  function automatic item_t rand_word();
    item_t       w;
    int unsigned pick;
    pick = $urandom_range(0, 99);
    if (pick < 45) w.kind = KIND_TICK;
    else if (pick < 75) w.kind = KIND_RETIRE;
    else if (pick < 96) w.kind = KIND_READ;
    else w.kind = KIND_RESTART;
    if ($urandom_range(0, 9) < 3) w.event_flags = 16'($urandom);
    else w.event_flags = prev_flags ^ (16'h0001 << $urandom_range(0, 15));
    if (w.kind == KIND_TICK) prev_flags = w.event_flags;
    pick = $urandom_range(0, 9);
    if (pick == 0) w.retire_pc = sb.start_pc;
    else if (pick == 1) w.retire_pc = sb.end_pc;
    else if (pick == 2) w.retire_pc = sb.start_pc ^ (64'd1 << $urandom_range(0, 63));
    else w.retire_pc = rand64();
    w.retire_interrupt = 1'($urandom_range(0, 1));
    w.retire_device = 1'($urandom_range(0, 1));
    w.counter_index = 5'($urandom_range(0, 31));
    return w;
  endfunction

  // present one word from a falling edge and hold it until taken
  task automatic send_word(item_t w);
    in_valid = 1'b1;
    in_kind = w.kind;
    in_event_flags = w.event_flags;
    in_retire_pc = w.retire_pc;
    in_retire_interrupt = w.retire_interrupt;
    in_retire_device = w.retire_device;
    in_counter_index = w.counter_index;
    @(posedge clk);
    while (in_stall !== 1'b0) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic wait_reads_done();
    while (sb.reads_due.size() != 0) @(negedge clk);
  endtask

  // idle point: all reads back, then let trailing words leave the pipe
  task automatic settle();
    in_valid = 1'b0;
    wait_reads_done();
    repeat (8) @(negedge clk);
  endtask

  task automatic write_reg(cfg_idx_t idx, logic [63:0] d);
    cfg_we = 1'b1;
    cfg_index = idx;
    cfg_wdata = d;
    @(posedge clk);
    sb.set_reg(idx, d);
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  // single-bit registers get random upper bits
  task automatic write_bit_reg(cfg_idx_t idx, bit v);
    logic [63:0] d;
    d = rand64();
    d[0] = v;
    write_reg(idx, d);
  endtask

  task automatic setup_phase(bit mon, bit roi, logic [63:0] s, logic [63:0] e);
    settle();
    write_bit_reg(CFG_MONITOR_EN, mon);
    write_bit_reg(CFG_ROI_EN, roi);
    write_reg(CFG_ROI_START, s);
    write_reg(CFG_ROI_END, e);
  endtask

  // bursts of random length with random gaps; now and then wait for all reads
  task automatic run_phase(int unsigned n);
    int unsigned sent;
    int unsigned burst;
    int unsigned i;
    sent = 0;
    while (sent < n) begin
      burst = $urandom_range(1, 24);
      for (i = 0; i < burst && sent < n; i++) begin
        send_word(rand_word());
        sent++;
      end
      in_valid = 1'b0;
      if ($urandom_range(0, 11) == 0) wait_reads_done();
      else repeat ($urandom_range(0, 6)) @(negedge clk);
    end
  endtask

  initial begin
    logic [63:0] same_pc;
    repeat (11) @(negedge clk);
    rst_n = 1'b1;

    // monitor off after reset: nothing counts
    send_word(mk(KIND_TICK, 16'hFFFF, '0, 1'b0, 1'b0, '0));
    send_word(mk(KIND_READ, '0, '0, 1'b0, 1'b0, 5'(IDX_CYCLES)));
    send_word(mk(KIND_READ, '0, '0, 1'b0, 1'b0, '1));

    // whole-run counting: each cause, episode edges, writeback extremes
    setup_phase(1'b1, 1'b0, '0, '1);
    send_word(mk(KIND_TICK, 16'h0000, '0, 1'b0, 1'b0, '0));
    send_word(mk(KIND_TICK, 16'hFFFF, '0, 1'b0, 1'b0, '0));
    send_word(mk(KIND_TICK, 16'hFFFF, '1, 1'b1, 1'b1, '1));
    send_word(mk(KIND_TICK, 16'h0001 << FLG_DIV_WAIT, '0, 1'b0, 1'b0, '0));
    send_word(mk(KIND_TICK, 16'h0001 << FLG_BR_FLUSH, '0, 1'b0, 1'b0, '0));
    send_word(mk(KIND_TICK, 16'h0001 << FLG_LOAD_USE, '0, 1'b0, 1'b0, '0));
    send_word(mk(KIND_TICK, 16'h0001 << FLG_ICACHE_WAIT, '0, 1'b0, 1'b0, '0));
    send_word(mk(KIND_RETIRE, '0, '0, 1'b1, 1'b0, '0));
    send_word(mk(KIND_RETIRE, '0, '1, 1'b0, 1'b1, '0));
    send_word(mk(KIND_READ, '0, '0, 1'b0, 1'b0, 5'(IDX_CYCLES)));
    send_word(mk(KIND_READ, '0, '0, 1'b0, 1'b0, IDX_SUM));
    send_word(mk(KIND_READ, '0, '0, 1'b0, 1'b0, 5'(IDX_EPIS0 + NUM_EPIS - 1)));
    send_word(mk(KIND_READ, '0, '0, 1'b0, 1'b0, IDX_SUM + 5'd1));
    send_word(mk(KIND_RESTART, '0, '0, 1'b0, 1'b0, '0));
    send_word(mk(KIND_READ, '0, '0, 1'b0, 1'b0, 5'(IDX_RETIRE)));

    // region mode: end before start, start clears, repeated start, end closes
    setup_phase(1'b1, 1'b1, 64'h0000_0000_8000_1000, 64'h0000_0000_8000_2000);
    send_word(mk(KIND_TICK, 16'h0040, '0, 1'b0, 1'b0, '0));
    send_word(mk(KIND_RETIRE, '0, 64'h0000_0000_8000_2000, 1'b1, 1'b1, '0));
    send_word(mk(KIND_RETIRE, '0, 64'h0000_0000_8000_1000, 1'b1, 1'b1, '0));
    send_word(mk(KIND_TICK, 16'h0040, '0, 1'b0, 1'b0, '0));
    send_word(mk(KIND_RETIRE, '0, 64'h0000_0000_8000_1000, 1'b0, 1'b1, '0));
    send_word(mk(KIND_RETIRE, '0, 64'h0000_0000_8000_2000, 1'b1, 1'b0, '0));
    send_word(mk(KIND_READ, '0, '0, 1'b0, 1'b0, 5'(IDX_CYCLES)));

    // random phases over several register settings
    setup_phase(1'b1, 1'b0, '0, '1);
    run_phase(300);
    setup_phase(1'b1, 1'b1, rand64(), rand64());
    run_phase(450);
    setup_phase(1'b1, 1'b1, '1, '0);
    run_phase(300);
    same_pc = rand64();
    setup_phase(1'b1, 1'b1, same_pc, same_pc);
    run_phase(150);
    setup_phase(1'b0, 1'b1, rand64(), rand64());
    run_phase(100);
    setup_phase(1'b1, 1'b0, '1, '1);
    run_phase(200);
    setup_phase(1'b1, 1'b1, rand64(), rand64());
    run_phase(200);

    settle();
    if (sb.errors == 0) begin
      $display("tb_perf_counter_roi_monitor: PASS");
    end else begin
      $display("tb_perf_counter_roi_monitor: FAIL");
    end
    $finish;
  end

endmodule
